@@ hdl/eeprom_page_transfer_splitter_macros.svh @@
// assertion macros shared by the splitter modules
`ifndef EEPROM_PAGE_TRANSFER_SPLITTER_MACROS_SVH
`define EEPROM_PAGE_TRANSFER_SPLITTER_MACROS_SVH

// same-cycle implication
`define EPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/eps_pkg.sv @@
`timescale 1ns / 1ps

package eps_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 6;
    localparam logic [7:0] BASE_RESET = 8'd160;

    typedef struct packed {
        logic        command;
        logic [15:0] start_address;
        logic [15:0] byte_count;
    } req_t;

    typedef struct packed {
        logic       direction;
        logic [8:0] device_address;
        logic [7:0] word_offset;
        logic [8:0] chunk_length;
        logic [9:0] buffer_offset;
        logic       range_error;
        logic       last_chunk;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_R,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic load;
        logic load_err;
        logic calc_q;
        logic calc_r;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic range_bad;
        logic last;
    } status_t;

endpackage

@@ hdl/eps_ctrl.sv @@
`timescale 1ns / 1ps
`include "eeprom_page_transfer_splitter_macros.svh"

module eps_ctrl
    import eps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    priority if (status.count_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.range_bad)
                    begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_ERR;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV_Q;
                    end
                end
            end
            ST_DIV_Q:
            begin
                cmd.calc_q = 1'b1;
                state_next = ST_DIV_R;
            end
            ST_DIV_R:
            begin
                cmd.calc_r = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.last ? ST_IDLE : ST_DIV_Q;
                end
            end
            ST_ERR:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `EPS_ASSERT_SAME(a_one_side, rsp_valid, !req_ready, "request taken while result pending")
    `EPS_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_ready && status.last, state_reg == ST_IDLE, "last beat did not end request")
    `EPS_ASSERT_NEXT(a_start, req_valid && req_ready && !status.count_zero && !status.range_bad, state_reg == ST_DIV_Q, "valid request not started")

endmodule

@@ hdl/eps_datapath.sv @@
`timescale 1ns / 1ps
`include "eeprom_page_transfer_splitter_macros.svh"

module eps_datapath
    import eps_pkg::*;
#(
    parameter int PAGE_BYTES  = 16,
    parameter int BLOCK_BYTES = 256,
    parameter int TOTAL_BYTES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  req_t       req,
    input  cmd_t       cmd,
    output status_t    status,
    output rsp_t       rsp
);

    localparam int AW = (TOTAL_BYTES > 1) ? $clog2(TOTAL_BYTES) : 1;
    localparam int RW = $clog2(TOTAL_BYTES + 1);
    localparam int LW = (RW > 9) ? RW : 9;
    localparam int SP = AW + $clog2(PAGE_BYTES);
    localparam int SB = AW + $clog2(BLOCK_BYTES);
    localparam int PWP = AW + SP + 1;
    localparam int PWB = AW + SB + 1;
    localparam int MP = ((1 << SP) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int MB = ((1 << SB) + BLOCK_BYTES - 1) / BLOCK_BYTES;

    logic [7:0]       base_reg, base_next;
    logic             dir_reg, dir_next;
    logic             err_reg, err_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    qp_reg, qp_next;
    logic [AW-1:0]    qb_reg, qb_next;
    logic [AW-1:0]    page_off_reg, page_off_next;
    logic [AW-1:0]    blk_off_reg, blk_off_next;

    logic [PWP-1:0]   prod_p;
    logic [PWB-1:0]   prod_b;
    logic [LW-1:0]    room_w;
    logic [LW-1:0]    rem_w;
    logic [LW-1:0]    len_w;
    logic [RW-1:0]    len_r;
    logic [16:0]      end_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            dir_reg      <= 1'b0;
            err_reg      <= 1'b0;
            addr_reg     <= '0;
            rem_reg      <= '0;
            done_reg     <= '0;
            cnt_reg      <= '0;
            qp_reg       <= '0;
            qb_reg       <= '0;
            page_off_reg <= '0;
            blk_off_reg  <= '0;
        end
        else
        begin
            base_reg     <= base_next;
            dir_reg      <= dir_next;
            err_reg      <= err_next;
            addr_reg     <= addr_next;
            rem_reg      <= rem_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            qp_reg       <= qp_next;
            qb_reg       <= qb_next;
            page_off_reg <= page_off_next;
            blk_off_reg  <= blk_off_next;
        end
    end

    // reciprocal multiply for the page and block quotients
    assign prod_p = PWP'(addr_reg) * PWP'(MP);
    assign prod_b = PWB'(addr_reg) * PWB'(MB);

    assign room_w = LW'(PAGE_BYTES) - LW'(page_off_reg);
    assign rem_w  = LW'(rem_reg);
    assign len_w  = (rem_w <= room_w) ? rem_w : room_w;
    assign len_r  = RW'(len_w);

    assign end_sum = 17'(req.start_address) + 17'(req.byte_count);

    assign status.count_zero = (req.byte_count == 16'd0);
    assign status.range_bad  = (end_sum > 17'(TOTAL_BYTES));
    assign status.last       = (rem_reg == len_r) || (&cnt_reg);

    always_comb
    begin
        base_next     = cfg_wr_en ? cfg_wr_data : base_reg;
        dir_next      = dir_reg;
        err_next      = err_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        done_next     = done_reg;
        cnt_next      = cnt_reg;
        qp_next       = qp_reg;
        qb_next       = qb_reg;
        page_off_next = page_off_reg;
        blk_off_next  = blk_off_reg;
        if (cmd.load_err)
        begin
            dir_next = req.command;
            err_next = 1'b1;
        end
        if (cmd.load)
        begin
            dir_next  = req.command;
            err_next  = 1'b0;
            addr_next = AW'(req.start_address);
            rem_next  = RW'(req.byte_count);
            done_next = '0;
            cnt_next  = '0;
        end
        if (cmd.calc_q)
        begin
            qp_next = prod_p[SP +: AW];
            qb_next = prod_b[SB +: AW];
        end
        if (cmd.calc_r)
        begin
            page_off_next = AW'(addr_reg - AW'(qp_reg * AW'(PAGE_BYTES)));
            blk_off_next  = AW'(addr_reg - AW'(qb_reg * AW'(BLOCK_BYTES)));
        end
        if (cmd.advance)
        begin
            addr_next = AW'(addr_reg + AW'(len_w));
            rem_next  = rem_reg - len_r;
            done_next = done_reg + len_r;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp.direction      = dir_reg;
        rsp.range_error    = err_reg;
        rsp.last_chunk     = err_reg | status.last;
        rsp.device_address = err_reg ? 9'd0 : 9'(base_reg) + 9'({qb_reg, 1'b0});
        rsp.word_offset    = err_reg ? 8'd0 : 8'(blk_off_reg);
        rsp.chunk_length   = err_reg ? 9'd0 : 9'(len_w);
        rsp.buffer_offset  = err_reg ? 10'd0 : 10'(done_reg);
    end

    `EPS_ASSERT_NEXT(a_done_adv, cmd.advance, done_reg == $past(done_reg) + $past(len_r), "buffer offset did not track chunk")
    `EPS_ASSERT_SAME(a_len_nonzero, cmd.advance, len_r != '0, "empty chunk sent")

endmodule

@@ hdl/eeprom_page_transfer_splitter.sv @@
`timescale 1ns / 1ps
// sequence: once a request is taken, each chunk passes the quotient multiply state (ST_DIV_Q),
// the remainder multiply state (ST_DIV_R) and the emit state (ST_EMIT), which waits for rsp_ready;
// a request gives at most 64 chunk beats, an out-of-range one a single error beat, a zero count none
// a new request is taken only in idle, after the last beat of the previous one has been taken
// reset: rst_n asynchronous active low, controller idle, base device address 160

module eeprom_page_transfer_splitter
    import eps_pkg::*;
#(
    parameter int PAGE_BYTES  = 16,
    parameter int BLOCK_BYTES = 256,
    parameter int TOTAL_BYTES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    cmd_t    cmd;
    status_t status;

    eps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    eps_datapath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .TOTAL_BYTES (TOTAL_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .cmd         (cmd),
        .status      (status),
        .rsp         (rsp)
    );

endmodule

@@ tb/eeprom_page_transfer_splitter_tb.sv @@
`timescale 1ns / 1ps

module eeprom_page_transfer_splitter_tb;
    import eps_pkg::*;

    localparam int PAGE_BYTES  = 16;
    localparam int BLOCK_BYTES = 256;
    localparam int TOTAL_BYTES = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int REPORT_LIMIT = 10;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;

    rsp_t       expected_chunks[$];
    logic [7:0] base_address;
    bit         sender_idles;
    bit         receiver_stalls;
    int         cycle_count;
    int         fail_count;
    int         requests_accepted;
    int         chunks_checked;
    int         errors_checked;
    int         base_settings;

    eeprom_page_transfer_splitter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     expected_chunks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // page-boundary split of one request into the expected beats; an out-of-range request gives one error beat
    task automatic split_transfer(input req_t item);
        rsp_t beat;
        int   addr;
        int   left;
        int   done;
        int   len;
        int   n;
        if (item.byte_count == 16'd0)
            return;
        beat = '0;
        beat.direction = item.command;
        if (int'(item.start_address) + int'(item.byte_count) > TOTAL_BYTES)
        begin
            beat.range_error = 1'b1;
            beat.last_chunk  = 1'b1;
            expected_chunks.push_back(beat);
            return;
        end
        addr = int'(item.start_address);
        left = int'(item.byte_count);
        done = 0;
        n    = 0;
        while (left > 0 && n < MAX_RESULTS)
        begin
            len = PAGE_BYTES - (addr % PAGE_BYTES);
            if (left < len)
                len = left;
            beat.device_address = 9'(int'(base_address) + ((addr / BLOCK_BYTES) << 1));
            beat.word_offset    = 8'(addr % BLOCK_BYTES);
            beat.chunk_length   = 9'(len);
            beat.buffer_offset  = 10'(done);
            left -= len;
            beat.last_chunk = (left == 0) || (n == MAX_RESULTS - 1);
            expected_chunks.push_back(beat);
            n++;
            addr += len;
            done += len;
        end
    endtask

    task automatic send_request(input logic cmd, input int start, input int count);
        req_t item;
        int   gap;
        item.command       = cmd;
        item.start_address = 16'(start);
        item.byte_count    = 16'(count);
        gap = sender_idles ? idle_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        split_transfer(item);
        requests_accepted++;
    endtask

    // drop valid, let every expected beat arrive, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_base_address(input logic [7:0] value);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        base_address = value;
        base_settings++;
    endtask

    // response beat checker
    always @(posedge clk)
    begin
        rsp_t want;
        int   bad;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_chunks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected beat at cycle %0d: dev=%0d off=%0d len=%0d err=%0d",
                             cycle_count, rsp.device_address, rsp.word_offset,
                             rsp.chunk_length, rsp.range_error);
            end
            else
            begin
                want = expected_chunks.pop_front();
                bad = 0;
                if (rsp.direction !== want.direction) bad++;
                if (rsp.device_address !== want.device_address) bad++;
                if (rsp.word_offset !== want.word_offset) bad++;
                if (rsp.chunk_length !== want.chunk_length) bad++;
                if (rsp.buffer_offset !== want.buffer_offset) bad++;
                if (rsp.range_error !== want.range_error) bad++;
                if (rsp.last_chunk !== want.last_chunk) bad++;
                if (want.range_error)
                    errors_checked++;
                else
                    chunks_checked++;
                if (bad != 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("beat mismatch at cycle %0d, %0d field(s) wrong",
                                 cycle_count, bad);
                        $display("  exp dir=%0d dev=%0d off=%0d len=%0d buf=%0d err=%0d last=%0d",
                                 want.direction, want.device_address, want.word_offset,
                                 want.chunk_length, want.buffer_offset, want.range_error,
                                 want.last_chunk);
                        $display("  act dir=%0d dev=%0d off=%0d len=%0d buf=%0d err=%0d last=%0d",
                                 rsp.direction, rsp.device_address, rsp.word_offset,
                                 rsp.chunk_length, rsp.buffer_offset, rsp.range_error,
                                 rsp.last_chunk);
                    end
                end
            end
        end
    end

    // receiver: runs of ready with random stalls in between
    initial
    begin
        int run;
        int gap;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            run = $urandom_range(1, 8);
            @(negedge clk);
            rsp_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            gap = receiver_stalls ? idle_gap() : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    task automatic test_zero_count();
        send_request(CMD_READ, 0, 0);
        send_request(CMD_WRITE, 16'hFFFF, 0);
        send_request(CMD_READ, 512, 0);
    endtask

    task automatic test_page_boundaries();
        send_request(CMD_READ, 0, 1);
        send_request(CMD_WRITE, 15, 2);
        send_request(CMD_READ, 7, 9);
        send_request(CMD_WRITE, 16, 16);
        send_request(CMD_READ, 255, 2);
        send_request(CMD_WRITE, 250, 300);
        send_request(CMD_READ, 1008, 16);
        send_request(CMD_WRITE, 3, 45);
    endtask

    task automatic test_range_limits();
        send_request(CMD_WRITE, 0, TOTAL_BYTES);
        send_request(CMD_READ, 0, TOTAL_BYTES + 1);
        send_request(CMD_READ, TOTAL_BYTES - 1, 1);
        send_request(CMD_WRITE, TOTAL_BYTES - 1, 2);
        send_request(CMD_READ, TOTAL_BYTES, 1);
        send_request(CMD_WRITE, 16'hFFFF, 16'hFFFF);
        send_request(CMD_READ, 0, 16'hFFFF);
    endtask

    task automatic test_base_extremes();
        set_base_address(8'd0);
        send_request(CMD_READ, 0, 20);
        send_request(CMD_WRITE, 770, 40);
        set_base_address(8'd255);
        send_request(CMD_WRITE, 760, 264);
        send_request(CMD_READ, 100, 0);
    endtask

    // sender holds off until everything outstanding has drained
    task automatic test_drain_pause();
        send_request(CMD_WRITE, $urandom_range(0, 900), $urandom_range(1, 120));
        wait_idle();
        send_request(CMD_READ, $urandom_range(0, 900), $urandom_range(1, 120));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int items, input logic [7:0] base,
                                       input bit req_idle, input bit rsp_idle);
        int pick;
        int start;
        int count;
        int room;
        set_base_address(base);
        sender_idles    = req_idle;
        receiver_stalls = rsp_idle;
        repeat (items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                start = $urandom_range(0, 16'hFFFF);
                count = 0;
            end
            else if (pick < 15)
            begin
                start = $urandom_range(0, 16'hFFFF);
                count = $urandom_range(1, 16'hFFFF);
            end
            else if (pick < 22)
            begin
                start = $urandom_range(0, TOTAL_BYTES - 1);
                count = TOTAL_BYTES - start + $urandom_range(1, 16);
            end
            else
            begin
                start = $urandom_range(0, TOTAL_BYTES - 1);
                room  = TOTAL_BYTES - start;
                if ($urandom_range(0, 9) < 7)
                    count = $urandom_range(1, (room < 48) ? room : 48);
                else
                    count = $urandom_range(1, room);
            end
            send_request(1'($urandom_range(0, 1)), start, count);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_valid       = 1'b0;
        req             = '0;
        base_address    = BASE_RESET;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        cycle_count     = 0;
        fail_count      = 0;
        base_settings   = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_count();
        test_page_boundaries();
        test_range_limits();
        test_base_extremes();
        test_drain_pause();
        test_random_traffic(50, BASE_RESET, 1'b1, 1'b1);
        test_random_traffic(50, 8'd0, 1'b0, 1'b0);
        test_random_traffic(50, 8'd255, 1'b1, 1'b0);
        test_random_traffic(50, 8'($urandom_range(1, 254)), 1'b0, 1'b1);
        wait_idle();

        if (expected_chunks.size() != 0)
            fail_count++;
        $display("%0d requests over %0d base address settings, zero counts and range limits incl",
                 requests_accepted, base_settings);
        $display("%0d page chunks and %0d range errors checked, %0d failures",
                 chunks_checked, errors_checked, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
